FILE: rtl/core/bhh_pkg.sv
// Shared types, constants and the raised-cosine table for the hall homing sequencer.
`default_nettype none

package bhh_pkg;

  localparam int COS_TABLE_ENTRIES = 256;
  localparam int COS_IDX_W = $clog2(COS_TABLE_ENTRIES + 1);

  localparam int FREQ_W = 17;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_FREQ    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_FREQ    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DIR      = 3'd5;

  localparam logic [7:0]        RST_DEBOUNCE_COUNT = 8'd5;
  localparam logic [15:0]       RST_VERIFY_TIMEOUT = 16'd100;
  localparam logic [FREQ_W-1:0] RST_SEARCH_FREQ    = 17'd2000;
  localparam logic [FREQ_W-1:0] RST_VERIFY_FREQ    = 17'd500;
  localparam logic [16:0]       RST_RAMP_STEP      = 17'd1311;
  localparam logic              RST_RIGHT_DIR      = 1'b1;

  localparam logic [16:0] Q16_ONE = 17'h10000;

  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598685;
  localparam logic [63:0] SIN_C5 = 64'd85569306;
  localparam logic [63:0] SIN_C7 = 64'd5026995;
  localparam logic [63:0] SIN_C9 = 64'd172273;

  typedef struct packed {
    logic [7:0]        debounce_count;
    logic [15:0]       verify_timeout;
    logic [FREQ_W-1:0] search_freq;
    logic [FREQ_W-1:0] verify_freq;
    logic [16:0]       ramp_step;
    logic              right_dir;
  } cfg_t;

  typedef struct packed {
    logic              driver_enable;
    logic              step_run;
    logic [FREQ_W-1:0] step_freq_hz;
    logic              direction;
    logic              led;
    logic              busy_res;
    logic              homed;
  } res_t;

  typedef logic [16:0] cos_table_t [0:COS_TABLE_ENTRIES];

  function automatic logic [FREQ_W-1:0] at_least_one(input logic [FREQ_W-1:0] f);
    return (f == '0) ? FREQ_W'(1) : f;
  endfunction

  // sin^2(pi/2 * x) in Q16, one entry per table step, built at elaboration
  function automatic cos_table_t build_cos_table();
    cos_table_t  tbl;
    logic [63:0] x;
    logic [63:0] xs;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sn;
    logic [63:0] s;
    for (int k = 0; k <= COS_TABLE_ENTRIES; k++) begin
      x  = (64'(k) << 16) / COS_TABLE_ENTRIES;
      xs = x << 14;
      x2 = (xs * xs) >> 30;
      t  = SIN_C9;
      t  = SIN_C7 - ((x2 * t) >> 30);
      t  = SIN_C5 - ((x2 * t) >> 30);
      t  = SIN_C3 - ((x2 * t) >> 30);
      t  = SIN_C1 - ((x2 * t) >> 30);
      sn = (xs * t) >> 30;
      s  = (sn * sn + (64'd1 << 43)) >> 44;
      tbl[k] = (s > 64'(Q16_ONE)) ? Q16_ONE : s[16:0];
    end
    return tbl;
  endfunction

  localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

`default_nettype wire

FILE: rtl/core/bhh_ramp.sv
// S-curve ramp frequency: table lookup of the ramp phase and interpolation.
`default_nettype none

module bhh_ramp (
  input  wire logic [16:0]                 ramp_phase,
  input  wire logic [bhh_pkg::FREQ_W-1:0]  fi,
  input  wire logic [bhh_pkg::FREQ_W-1:0]  ff,
  output logic [bhh_pkg::FREQ_W-1:0]       freq
);
  import bhh_pkg::*;

  logic [29:0]          scaled;
  logic [COS_IDX_W-1:0] k;
  logic [16:0]          s;
  logic [FREQ_W-1:0]    diff;
  logic [33:0]          prod;
  logic [34:0]          base;
  logic [34:0]          v;
  logic [34:0]          vr;
  logic [FREQ_W-1:0]    r;

  assign scaled = 30'(ramp_phase) * 30'(COS_TABLE_ENTRIES);
  assign k      = scaled[16 +: COS_IDX_W];
  assign s      = COS_TABLE[k];
  assign diff   = (ff >= fi) ? (ff - fi) : (fi - ff);
  assign prod   = 34'(diff) * 34'(s);
  assign base   = {2'b00, fi, 16'h0000};
  assign v      = (ff >= fi) ? (base + 35'(prod)) : (base - 35'(prod));
  assign vr     = v + 35'd32768;
  assign r      = vr[32:16];
  assign freq   = at_least_one(r);

endmodule

`default_nettype wire

FILE: rtl/core/bhh_seq.sv
// Homing sequencer state: search, ramp, verify, endstop escape, back seek and final seek.
`default_nettype none

module bhh_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire logic          start_req,
  input  wire logic          hall_level,
  input  wire bhh_pkg::cfg_t cfg,
  output bhh_pkg::res_t      res
);
  import bhh_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SEARCH, PH_RAMP, PH_V_ENTRY, PH_V_LEAVE, PH_V_TIMED,
    PH_ESC_LEAVE, PH_ESC_FIND, PH_ESC_PASS, PH_BACK_SEEK, PH_FINAL_SEEK
  } phase_t;

  typedef enum logic [1:0] {
    PATH_RUN, PATH_START_RIGHT, PATH_START_LEFT, PATH_SPARE
  } path_t;

  phase_t            phase, phase_next;
  logic [7:0]        db_cnt, db_cnt_next;
  logic [15:0]       elapsed, elapsed_next;
  logic              cur_dir, cur_dir_next;
  logic [16:0]       ramp_phase, ramp_phase_next;
  path_t             ret_path, ret_path_next;
  logic [FREQ_W-1:0] freq, freq_next;
  logic              led, led_next;
  logic              homed, homed_next;

  logic              mag;
  logic [FREQ_W-1:0] ramp_freq;
  logic              do_timed;
  logic [15:0]       el_base;
  logic [8:0]        db;
  logic [17:0]       ramp_sum;
  logic              busy;

  // returns {hit, new count}
  function automatic logic [8:0] debounce(input logic match, input logic [7:0] cnt,
                                          input logic [7:0] need);
    logic [7:0] c;
    c = match ? ((cnt == 8'hFF) ? cnt : cnt + 8'd1) : 8'd0;
    return {match && (c >= need), c};
  endfunction

  bhh_ramp u_ramp (
    .ramp_phase (ramp_phase),
    .fi         (cfg.search_freq),
    .ff         (cfg.verify_freq),
    .freq       (ramp_freq)
  );

  assign mag      = !hall_level;
  assign ramp_sum = 18'(ramp_phase) + 18'(cfg.ramp_step);

  always_comb begin
    phase_next      = phase;
    db_cnt_next     = db_cnt;
    elapsed_next    = elapsed;
    cur_dir_next    = cur_dir;
    ramp_phase_next = ramp_phase;
    ret_path_next   = ret_path;
    freq_next       = freq;
    led_next        = led;
    homed_next      = homed;
    do_timed        = 1'b0;
    el_base         = elapsed;
    db              = '0;

    unique case (phase)
      PH_SEARCH: begin
        db = debounce(mag, db_cnt, cfg.debounce_count);
        db_cnt_next = db[7:0];
        if (db[8]) begin
          db_cnt_next = '0;
          if (cfg.ramp_step == '0 || cfg.search_freq == cfg.verify_freq) begin
            freq_next     = at_least_one(cfg.verify_freq);
            ret_path_next = PATH_RUN;
            phase_next    = PH_V_ENTRY;
          end else begin
            ramp_phase_next = '0;
            phase_next      = PH_RAMP;
          end
        end
      end
      PH_RAMP: begin
        freq_next = ramp_freq;
        if (ramp_phase >= Q16_ONE) begin
          freq_next     = at_least_one(cfg.verify_freq);
          ret_path_next = PATH_RUN;
          phase_next    = PH_V_ENTRY;
          db_cnt_next   = '0;
        end else begin
          ramp_phase_next = (ramp_sum > 18'(Q16_ONE)) ? Q16_ONE : ramp_sum[16:0];
        end
      end
      PH_V_ENTRY: begin
        if (mag) begin
          phase_next  = PH_V_LEAVE;
          db_cnt_next = '0;
        end else begin
          phase_next = PH_V_TIMED;
          do_timed   = 1'b1;
          el_base    = '0;
        end
      end
      PH_V_LEAVE: begin
        db = debounce(!mag, db_cnt, cfg.debounce_count);
        db_cnt_next = db[7:0];
        if (db[8]) begin
          elapsed_next = '0;
          phase_next   = PH_V_TIMED;
          db_cnt_next  = '0;
        end
      end
      PH_V_TIMED: begin
        do_timed = 1'b1;
      end
      PH_ESC_LEAVE: begin
        db = debounce(!mag, db_cnt, cfg.debounce_count);
        db_cnt_next = db[7:0];
        if (db[8]) begin
          phase_next  = PH_ESC_FIND;
          db_cnt_next = '0;
        end
      end
      PH_ESC_FIND: begin
        db = debounce(mag, db_cnt, cfg.debounce_count);
        db_cnt_next = db[7:0];
        if (db[8]) begin
          phase_next  = PH_ESC_PASS;
          db_cnt_next = '0;
        end
      end
      PH_ESC_PASS: begin
        db = debounce(!mag, db_cnt, cfg.debounce_count);
        db_cnt_next = db[7:0];
        if (db[8]) begin
          led_next    = 1'b0;
          freq_next   = at_least_one(cfg.search_freq);
          phase_next  = PH_SEARCH;
          db_cnt_next = '0;
        end
      end
      PH_BACK_SEEK: begin
        db = debounce(mag, db_cnt, cfg.debounce_count);
        db_cnt_next = db[7:0];
        if (db[8]) begin
          freq_next     = at_least_one(cfg.verify_freq);
          ret_path_next = PATH_START_LEFT;
          phase_next    = PH_V_ENTRY;
          db_cnt_next   = '0;
        end
      end
      PH_FINAL_SEEK: begin
        db = debounce(mag, db_cnt, cfg.debounce_count);
        db_cnt_next = db[7:0];
        if (db[8]) begin
          led_next    = 1'b1;
          homed_next  = 1'b1;
          phase_next  = PH_IDLE;
          db_cnt_next = '0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (start_req) begin
          homed_next   = 1'b0;
          led_next     = 1'b0;
          cur_dir_next = cfg.right_dir;
          db_cnt_next  = '0;
          if (mag) begin
            freq_next     = at_least_one(cfg.verify_freq);
            ret_path_next = PATH_START_RIGHT;
            phase_next    = PH_V_LEAVE;
          end else begin
            freq_next  = at_least_one(cfg.search_freq);
            phase_next = PH_SEARCH;
          end
        end
      end
    endcase

    // overtravel sample: a second magnet is an endstop, a timeout confirms home
    if (do_timed) begin
      db = debounce(mag, db_cnt, cfg.debounce_count);
      db_cnt_next  = db[7:0];
      elapsed_next = el_base;
      if (db[8]) begin
        led_next     = 1'b1;
        cur_dir_next = !cur_dir;
        freq_next    = at_least_one(cfg.search_freq);
        phase_next   = PH_ESC_LEAVE;
        db_cnt_next  = '0;
      end else if (el_base >= cfg.verify_timeout) begin
        db_cnt_next = '0;
        phase_next  = PH_FINAL_SEEK;
        case (ret_path)
          PATH_START_RIGHT: begin
            cur_dir_next = !cfg.right_dir;
            phase_next   = PH_BACK_SEEK;
          end
          PATH_START_LEFT: begin
            cur_dir_next = cfg.right_dir;
          end
          default: begin
            cur_dir_next = !cur_dir;
            freq_next    = at_least_one(cfg.verify_freq);
          end
        endcase
      end else if (el_base != 16'hFFFF) begin
        elapsed_next = el_base + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      db_cnt     <= '0;
      elapsed    <= '0;
      cur_dir    <= RST_RIGHT_DIR;
      ramp_phase <= '0;
      ret_path   <= PATH_RUN;
      freq       <= at_least_one(RST_SEARCH_FREQ);
      led        <= 1'b0;
      homed      <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      db_cnt     <= db_cnt_next;
      elapsed    <= elapsed_next;
      cur_dir    <= cur_dir_next;
      ramp_phase <= ramp_phase_next;
      ret_path   <= ret_path_next;
      freq       <= freq_next;
      led        <= led_next;
      homed      <= homed_next;
    end
  end

  assign busy              = (phase_next != PH_IDLE);
  assign res.driver_enable = busy;
  assign res.step_run      = busy && (phase_next != PH_RAMP);
  assign res.step_freq_hz  = freq_next;
  assign res.direction     = cur_dir_next;
  assign res.led           = led_next;
  assign res.busy_res      = busy;
  assign res.homed         = homed_next;

endmodule

`default_nettype wire

FILE: rtl/core/bidirectional_hall_homing.sv
// Top level of the hall homing sequencer: config registers, stream ports, result register.
`default_nettype none

// Each input item is one sensor sample tick and yields exactly one result item with the
// drive outputs after that tick. The sequencer steps once per item, so one item is taken
// every clock unless the output stalls; its result is registered in the cycle after
// acceptance. A new item is taken while that result waits, as long as the downstream side
// takes the result in the same cycle. Configuration is written through cfg_we/cfg_index/
// cfg_data and should change only while the block is idle.
module bidirectional_hall_homing (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // [0] start_req, [1] hall_level, [7:2] zero
  input  wire logic [bhh_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // [0] driver_enable, [1] step_run, [18:2] step_freq_hz, [19] direction, [20] led,
  // [21] busy_res, [22] homed, [23] zero
  output logic [bhh_pkg::OUT_DATA_W-1:0]        m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [bhh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bhh_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bhh_pkg::*;

  cfg_t cfg;
  res_t res;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_count <= RST_DEBOUNCE_COUNT;
      cfg.verify_timeout <= RST_VERIFY_TIMEOUT;
      cfg.search_freq    <= RST_SEARCH_FREQ;
      cfg.verify_freq    <= RST_VERIFY_FREQ;
      cfg.ramp_step      <= RST_RAMP_STEP;
      cfg.right_dir      <= RST_RIGHT_DIR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_COUNT: cfg.debounce_count <= cfg_data[7:0];
        CFG_VERIFY_TIMEOUT: cfg.verify_timeout <= cfg_data[15:0];
        CFG_SEARCH_FREQ:    cfg.search_freq    <= cfg_data;
        CFG_VERIFY_FREQ:    cfg.verify_freq    <= cfg_data;
        CFG_RAMP_STEP:      cfg.ramp_step      <= cfg_data;
        CFG_RIGHT_DIR:      cfg.right_dir      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  bhh_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .advance    (accept),
    .start_req  (s_tdata[0]),
    .hall_level (s_tdata[1]),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0, res.homed, res.busy_res, res.led, res.direction,
                  res.step_freq_hz, res.step_run, res.driver_enable};
    end
  end

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid) else $error("accepted item produced no result");

  a_enable_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == m_tdata[21])) else $error("enable and busy disagree");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> m_tdata[21]) else $error("step run while not busy");

  a_freq_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[18:2] != '0)) else $error("step frequency is zero");

endmodule

`default_nettype wire
